@@ hdl/scmap_pkg.sv @@
// ----------------------------------------------------------------------------
// scmap_pkg
// Shared types and constants of the sorted character-keyed map.
// ----------------------------------------------------------------------------
package scmap_pkg;

  localparam int unsigned CAPACITY_DEF    = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  key;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        hit;
    logic        dropped;
  } out_item_t;

endpackage

@@ hdl/scmap_ram.sv @@
// ----------------------------------------------------------------------------
// scmap_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scmap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/scmap_ctrl.sv @@
// ----------------------------------------------------------------------------
// scmap_ctrl
// Sequencer: binary search over the key memory, overwrite or ordered insert
// with an entry-by-entry shift, and the result register.
// ----------------------------------------------------------------------------
module scmap_ctrl #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  scmap_pkg::in_item_t         in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output scmap_pkg::out_item_t        out_item_o,
  input  logic [31:0]                 dflt_i,
  output logic [$clog2(CAPACITY)-1:0] rd_addr_o,
  input  logic [7:0]                  rd_key_i,
  input  logic [VALUE_WIDTH-1:0]      rd_val_i,
  output logic [$clog2(CAPACITY)-1:0] wr_addr_o,
  output logic                        key_we_o,
  output logic [7:0]                  wr_key_o,
  output logic                        val_we_o,
  output logic [VALUE_WIDTH-1:0]      wr_val_o
);
  import scmap_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_PROBE, ST_COMPARE, ST_SHIFT, ST_INSERT, ST_FINISH
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      cnt_q, lo_q, hi_q, mid_q, n_q;
  logic [AW-1:0]      dest_q;
  logic               pend_q;
  logic               op_q;
  logic [7:0]         key_q;
  logic [VALUE_WIDTH-1:0] nv_q;
  out_item_t          res_q, out_q;
  logic               out_valid_q;

  logic [CW:0]        sum;
  logic [CW-1:0]      mid;
  logic               present;
  logic               full;

  assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = CW'(sum >> 1);
  assign present = (lo_q < cnt_q) && (rd_key_i == key_q);
  assign full    = (cnt_q == CW'(CAPACITY));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    rd_addr_o = '0;
    wr_addr_o = '0;
    key_we_o  = 1'b0;
    val_we_o  = 1'b0;
    wr_key_o  = rd_key_i;
    wr_val_o  = rd_val_i;
    unique case (state_q)
      ST_SEARCH: begin
        rd_addr_o = (lo_q == hi_q) ? lo_q[AW-1:0] : mid[AW-1:0];
      end
      ST_COMPARE: begin
        wr_addr_o = lo_q[AW-1:0];
        wr_val_o  = nv_q;
        val_we_o  = (op_q == OP_ASSIGN) && present;
      end
      ST_SHIFT: begin
        rd_addr_o = AW'(n_q - CW'(1));
        wr_addr_o = dest_q;
        key_we_o  = pend_q;
        val_we_o  = pend_q;
      end
      ST_INSERT: begin
        wr_addr_o = lo_q[AW-1:0];
        wr_key_o  = key_q;
        wr_val_o  = nv_q;
        key_we_o  = 1'b1;
        val_we_o  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      n_q         <= '0;
      dest_q      <= '0;
      pend_q      <= 1'b0;
      op_q        <= OP_LOOKUP;
      key_q       <= '0;
      nv_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_item_i.opcode;
            key_q   <= in_item_i.key;
            nv_q    <= VALUE_WIDTH'(in_item_i.data_word);
            lo_q    <= '0;
            hi_q    <= cnt_q;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (lo_q == hi_q) begin
            state_q <= ST_COMPARE;
          end else begin
            mid_q   <= mid;
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (rd_key_i < key_q) begin
            lo_q <= mid_q + CW'(1);
          end else begin
            hi_q <= mid_q;
          end
          state_q <= ST_SEARCH;
        end
        ST_COMPARE: begin
          res_q.hit        <= present;
          res_q.dropped    <= (op_q == OP_ASSIGN) && !present && full;
          res_q.read_value <= (op_q == OP_LOOKUP) ?
                              (present ? 32'(rd_val_i) : dflt_i) : '0;
          if ((op_q == OP_LOOKUP) || present || full) begin
            state_q <= ST_FINISH;
          end else begin
            n_q     <= cnt_q;
            pend_q  <= 1'b0;
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (n_q > lo_q) begin
            dest_q <= n_q[AW-1:0];
            pend_q <= 1'b1;
            n_q    <= n_q - CW'(1);
          end else begin
            pend_q  <= 1'b0;
            state_q <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("entry count moved by more than one");

  a_search_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (lo_q <= hi_q && hi_q <= cnt_q))
    else $error("search bounds crossed");

  a_shift_above : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && key_we_o) |-> ({1'b0, wr_addr_o} > lo_q))
    else $error("shift wrote at or below insert position");

  a_out_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

endmodule

@@ hdl/sorted_char_keyed_map_top.sv @@
// Lookup: a binary search of up to ceil(log2(n+1)) probes, then a compare of the found entry.
// Assign: as lookup, plus a shift of every entry above the key and the write for an insert.
// The slowest item is an insert at the bottom of 255 entries; one item at a time.
// The shift is set by the single write port and single read port of the key and value memories.
// Reset clears the entry count and default value; the memories are not cleared.
// ----------------------------------------------------------------------------
// sorted_char_keyed_map_top
// Sparse map from 8-bit keys to data words, kept sorted in on-chip memories.
// ----------------------------------------------------------------------------
module sorted_char_keyed_map_top #(
  parameter int unsigned CAPACITY    = scmap_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = scmap_pkg::VALUE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  scmap_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output scmap_pkg::out_item_t out_item_o
);
  import scmap_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic [31:0]            dflt_q;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [7:0]             rd_key, wr_key;
  logic [VALUE_WIDTH-1:0] rd_val, wr_val;
  logic                   key_we, val_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      dflt_q <= 32'(VALUE_WIDTH'(cfg_wdata_i));
    end
  end

  scmap_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(wr_addr),
    .wdata_i(wr_key),
    .raddr_i(rd_addr),
    .rdata_o(rd_key)
  );

  scmap_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(wr_addr),
    .wdata_i(wr_val),
    .raddr_i(rd_addr),
    .rdata_o(rd_val)
  );

  scmap_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .dflt_i     (dflt_q),
    .rd_addr_o  (rd_addr),
    .rd_key_i   (rd_key),
    .rd_val_i   (rd_val),
    .wr_addr_o  (wr_addr),
    .key_we_o   (key_we),
    .wr_key_o   (wr_key),
    .val_we_o   (val_we),
    .wr_val_o   (wr_val)
  );

endmodule

@@ bench/map_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// map_scoreboard_pkg
// Scoreboard for the sorted character-keyed map. It keeps its own sorted copy
// of the stored entries, works out the result of every accepted item and
// checks each returned result against the oldest outstanding one.
// ----------------------------------------------------------------------------
package map_scoreboard_pkg;

  import scmap_pkg::*;

  class map_scoreboard;
    int unsigned capacity;
    logic [7:0]  key_tbl [256];
    logic [31:0] val_tbl [256];
    int unsigned n_entries;
    logic [31:0] default_val;
    out_item_t   expected_q [$];
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned n_lookup;
    int unsigned n_hit;
    int unsigned n_insert;
    int unsigned n_overwrite;
    int unsigned n_drop;

    function new(int unsigned cap);
      capacity    = cap;
      n_entries   = 0;
      default_val = '0;
      n_fail      = 0;
      n_checked   = 0;
      n_lookup    = 0;
      n_hit       = 0;
      n_insert    = 0;
      n_overwrite = 0;
      n_drop      = 0;
    endfunction

    function void set_default(logic [31:0] value);
      default_val = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(in_item_t it);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned n;
      bit          present;
      out_item_t   res;
      lo = 0;
      hi = n_entries;
      while (lo != hi) begin
        mid = (lo + hi) / 2;
        if (key_tbl[mid] < it.key) lo = mid + 1;
        else hi = mid;
      end
      present        = (lo < n_entries) && (key_tbl[lo] == it.key);
      res.read_value = '0;
      res.hit        = present;
      res.dropped    = 1'b0;
      if (it.opcode == OP_LOOKUP) begin
        n_lookup++;
        if (present) n_hit++;
        res.read_value = present ? val_tbl[lo] : default_val;
      end else if (present) begin
        n_overwrite++;
        val_tbl[lo] = it.data_word;
      end else if (n_entries >= capacity) begin
        n_drop++;
        res.dropped = 1'b1;
      end else begin
        n_insert++;
        for (n = n_entries; n > lo; n--) begin
          key_tbl[n] = key_tbl[n-1];
          val_tbl[n] = val_tbl[n-1];
        end
        key_tbl[lo] = it.key;
        val_tbl[lo] = it.data_word;
        n_entries++;
      end
      expected_q.push_back(res);
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      if (n_fail < 10)
        $display("%0t: %s: expected value %h hit %b dropped %b, got value %h hit %b dropped %b",
                 $time, what, want.read_value, want.hit, want.dropped,
                 got.read_value, got.hit, got.dropped);
      n_fail++;
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_value !== want.read_value || got.hit !== want.hit ||
          got.dropped !== want.dropped)
        report("result mismatch", want, got);
    endfunction
  endclass

endpackage

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_char_keyed_map_top. Directed lookups and assigns at the
// key and value extremes, then random traffic, a full sweep that fills every
// key and random traffic on the full store, all under random handshake gaps,
// with two long output stalls and several default values.
// ----------------------------------------------------------------------------
module tb;

  import scmap_pkg::*;
  import map_scoreboard_pkg::*;

  localparam int unsigned MAP_CAPACITY = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  map_scoreboard sb;
  bit            in_burst   = 1'b0;
  bit            out_burst  = 1'b0;
  int unsigned   n_results  = 0;
  int unsigned   n_cfg      = 0;
  int unsigned   n_holds    = 0;
  int unsigned   cycle_cnt  = 0;

  sorted_char_keyed_map_top #(
    .CAPACITY    (MAP_CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH_DEF)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_item_t mk(logic op, logic [7:0] k, logic [31:0] v);
    in_item_t it;
    it.opcode    = op;
    it.key       = k;
    it.data_word = v;
    return it;
  endfunction

  function automatic in_item_t rand_item(int unsigned assign_pct);
    in_item_t it;
    it.opcode = ($urandom_range(0, 99) < assign_pct) ? OP_ASSIGN : OP_LOOKUP;
    it.key    = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: it.data_word = '0;
      1: it.data_word = '1;
      default: it.data_word = $urandom;
    endcase
    return it;
  endfunction

  task automatic offer(in_item_t it);
    int unsigned gap;
    bit          acc;
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk);
      acc = in_ready;
      if (acc) sb.note_request(it);
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic write_default(logic [31:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_default(value);
    n_cfg++;
  endtask

  // result side
  initial begin
    int unsigned stall;
    bit          got_v;
    out_item_t   got;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      if (n_results == 120 || n_results == 480) begin
        stall = LONG_HOLD;
        n_holds++;
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        got_v = out_valid;
        got   = out_item;
        @(posedge clk);
      end while (!got_v);
      sb.check_response(got);
      n_results++;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned key_order [256];
    int unsigned i;
    int unsigned j;
    int unsigned tmp;
    sb = new(MAP_CAPACITY);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(mk(OP_LOOKUP, 8'h00, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF));
    offer(mk(OP_ASSIGN, 8'h80, 32'hFFFF_FFFF));
    offer(mk(OP_ASSIGN, 8'h00, 32'h0000_0000));
    offer(mk(OP_ASSIGN, 8'hFF, 32'hA5A5_A5A5));
    offer(mk(OP_ASSIGN, 8'h7F, 32'h5A5A_5A5A));
    offer(mk(OP_ASSIGN, 8'h81, 32'h1234_5678));
    offer(mk(OP_LOOKUP, 8'h00, 32'hFFFF_FFFF));
    offer(mk(OP_LOOKUP, 8'hFF, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'h80, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'h7F, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'h81, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'h01, 32'h0000_0000));
    offer(mk(OP_ASSIGN, 8'h80, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'h80, 32'hFFFF_FFFF));
    offer(mk(OP_LOOKUP, 8'hFE, 32'hFFFF_FFFF));
    write_default(32'hFFFF_FFFF);
    offer(mk(OP_LOOKUP, 8'h40, 32'h0000_0000));
    offer(mk(OP_LOOKUP, 8'h00, 32'h0000_0000));
    offer(mk(OP_ASSIGN, 8'h40, 32'hFFFF_FFFF));
    offer(mk(OP_LOOKUP, 8'h40, 32'h0000_0000));

    write_default($urandom);
    repeat (250) offer(rand_item(55));

    // fill every key in random order so the store ends up full
    write_default('0);
    for (i = 0; i < 256; i++) key_order[i] = i;
    for (i = 255; i > 0; i--) begin
      j            = $urandom_range(0, i);
      tmp          = key_order[i];
      key_order[i] = key_order[j];
      key_order[j] = tmp;
    end
    for (i = 0; i < 256; i++) offer(mk(OP_ASSIGN, 8'(key_order[i]), $urandom));

    write_default($urandom);
    repeat (170) offer(rand_item(50));

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d lookups (%0d hits), %0d inserts, %0d overwrites, %0d refused;",
             sb.n_lookup, sb.n_hit, sb.n_insert, sb.n_overwrite, sb.n_drop);
    $display("store reached %0d of %0d entries, %0d default writes, %0d long holds, %0d results.",
             sb.n_entries, MAP_CAPACITY, n_cfg, n_holds, sb.n_checked);
    if (sb.n_fail == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/scmap_pkg.sv
hdl/scmap_ram.sv
hdl/scmap_ctrl.sv
hdl/sorted_char_keyed_map_top.sv
bench/map_scoreboard_pkg.sv
bench/tb.sv
